// File: rtl/mtt_pkg.sv
// mtt_pkg: shared types and constants for the markup text tokenizer
// no dependencies; imported by the parser, output buffer, top level and testbench
package mtt_pkg;

	localparam int unsigned NAME_CNT_W = 5;

	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] BOLD_MAX = 8'hff;

	localparam logic CFG_MARKUP = 1'b0;
	localparam logic CFG_ESCAPE = 1'b1;

	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_BREAK = 1'b1;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_OPEN = 2'd1,
		MODE_NAME = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic                  esc_pending;
		logic                  closing;
		logic                  bold_pending;
		logic [NAME_CNT_W-1:0] name_cnt;
		logic [7:0]            bold_level;
	} parse_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] glyph;
		logic       bold;
	} event_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			return c + CASE_OFS;
		end
		return c;
	endfunction

endpackage

// File: rtl/mtt_parser.sv
// mtt_parser: next-state and event logic for one text word
// depends on mtt_pkg
module mtt_parser import mtt_pkg::*; #(
	parameter int unsigned NAME_LIMIT = 30
) (
	input  parse_state_t st,
	input  logic [7:0]   char_code,
	input  logic         last_char,
	input  logic         markup_en,
	input  logic         escape_en,
	output parse_state_t st_next,
	output logic         emit,
	output event_t       evt
);

	localparam logic [NAME_CNT_W-1:0] LIMIT = NAME_CNT_W'(NAME_LIMIT);

	logic                  feed;
	logic [7:0]            c;
	logic [7:0]            lc;
	logic [NAME_CNT_W-1:0] cnt_inc;
	logic                  bold_act;
	parse_state_t          ns;

	always_comb begin
		feed = 1'b0;
		c    = char_code;
		if (st.esc_pending) begin
			feed = 1'b1;
			c    = (char_code == CH_N) ? CH_LF : char_code;
		end else if (!(char_code == CH_BSL && escape_en)) begin
			feed = 1'b1;
		end
	end

	assign lc      = to_lower(c);
	assign cnt_inc = st.name_cnt + NAME_CNT_W'(1);

	// next state
	always_comb begin
		ns             = st;
		ns.esc_pending = !st.esc_pending && char_code == CH_BSL && escape_en;
		bold_act       = 1'b0;
		if (feed) begin
			unique case (st.mode)
				MODE_OPEN: begin
					if (c == CH_GT || c == CH_LT) begin
						ns.mode = MODE_TEXT;
					end else begin
						ns.mode         = MODE_NAME;
						ns.closing      = (lc == CH_SLASH);
						ns.bold_pending = (lc == CH_B);
						ns.name_cnt     = '0;
					end
				end
				MODE_NAME: begin
					if (c == CH_LT || c == CH_GT) begin
						bold_act = 1'b1;
					end else begin
						if (st.closing && st.name_cnt == '0) begin
							ns.bold_pending = (lc == CH_B);
						end
						ns.name_cnt = cnt_inc;
						bold_act    = (cnt_inc >= LIMIT);
					end
				end
				default: begin
					ns.mode = MODE_TEXT;
					if (c == CH_LT && markup_en) begin
						ns.mode = MODE_OPEN;
					end
				end
			endcase
		end
		// tag end: apply pending bold step and return to text
		if (bold_act) begin
			if (ns.bold_pending) begin
				if (ns.closing) begin
					if (st.bold_level != 8'd0) begin
						ns.bold_level = st.bold_level - 8'd1;
					end
				end else if (st.bold_level != BOLD_MAX) begin
					ns.bold_level = st.bold_level + 8'd1;
				end
			end
			ns.mode         = MODE_TEXT;
			ns.closing      = 1'b0;
			ns.bold_pending = 1'b0;
			ns.name_cnt     = '0;
		end
		if (last_char) begin
			ns = '{mode: MODE_TEXT, esc_pending: 1'b0, closing: 1'b0,
				bold_pending: 1'b0, name_cnt: '0, bold_level: 8'd0};
		end
		st_next = ns;
	end

	// event outputs
	always_comb begin
		emit      = 1'b0;
		evt.kind  = KIND_GLYPH;
		evt.glyph = c;
		evt.bold  = st.bold_level != 8'd0;
		if (feed) begin
			unique case (st.mode)
				MODE_OPEN: begin
					if (c == CH_LT) begin
						emit      = 1'b1;
						evt.glyph = CH_LT;
					end
				end
				MODE_NAME: ;
				default: begin
					if (!(c == CH_LT && markup_en)) begin
						emit = 1'b1;
						if (c == CH_NUL || c == CH_LF) begin
							evt.kind  = KIND_BREAK;
							evt.glyph = CH_NUL;
						end
					end
				end
			endcase
		end
	end

endmodule

// File: rtl/mtt_outbuf.sv
// mtt_outbuf: output register with one skid entry for event words
// depends on mtt_pkg
module mtt_outbuf import mtt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_evt,
	output logic   full,
	output logic   out_valid,
	input  logic   out_stall,
	output event_t out_evt
);

	logic   out_valid_q;
	logic   skid_valid_q;
	event_t out_q;
	event_t skid_q;
	logic   load;

	assign load      = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_evt   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_valid_q ? skid_q : push_evt;
		end else if (push) begin
			skid_q <= push_evt;
		end
	end

endmodule

// File: rtl/markup_text_tokenizer_core.sv
// markup_text_tokenizer_core: text byte stream to glyph / line break events
// depends on mtt_pkg, mtt_parser, mtt_outbuf
// an event word is registered in the result register, or in the skid entry while the output stalls
// throughput: one byte per cycle while the skid entry is free; the parser state register is the only loop
// output side has a result register plus one skid entry, so a stalled output
// backs up into in_stall only after two events wait
// reset: async active low, clears parser state, bold level and both config bits
module markup_text_tokenizer_core import mtt_pkg::*; #(
	parameter int unsigned NAME_LIMIT = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	// output events
	output logic       out_valid,
	input  logic       out_stall,
	output logic       event_kind,
	output logic [7:0] glyph_code,
	output logic       bold_on,
	// config writes
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	// config registers
	logic markup_en_q;
	logic escape_en_q;

	// running parser state: mode, escape flag, tag flags, name count, bold level
	parse_state_t st_q;
	parse_state_t st_next;

	logic   accept;
	logic   emit;
	event_t evt;
	event_t out_evt;
	logic   buf_full;

	// a byte is taken whenever the skid entry is free
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markup_en_q <= 1'b0;
			escape_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MARKUP: markup_en_q <= cfg_data;
				CFG_ESCAPE: escape_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// all per-byte decisions are combinational compare/select logic
	mtt_parser #(
		.NAME_LIMIT(NAME_LIMIT)
	) u_parser (
		.st        (st_q),
		.char_code (char_code),
		.last_char (last_char),
		.markup_en (markup_en_q),
		.escape_en (escape_en_q),
		.st_next   (st_next),
		.emit      (emit),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_TEXT, esc_pending: 1'b0, closing: 1'b0,
				bold_pending: 1'b0, name_cnt: '0, bold_level: 8'd0};
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	// result register and skid entry
	mtt_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_evt  (evt),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_evt   (out_evt)
	);

	assign event_kind = out_evt.kind;
	assign glyph_code = out_evt.glyph;
	assign bold_on    = out_evt.bold;

endmodule

// File: sim/markup_text_tokenizer_core_tb.sv
// markup_text_tokenizer_core_tb: self-checking bench for the markup text tokenizer core
// drives text bytes and config writes, predicts every glyph / line break event in-bench
// depends on mtt_pkg and markup_text_tokenizer_core only
`timescale 1ns / 100ps

module markup_text_tokenizer_core_tb import mtt_pkg::*; ();

	localparam int unsigned TAG_NAME_MAX  = 30;
	localparam int unsigned RANDOM_WORDS  = 240;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned MAX_REPORTS   = 10;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_stall;
	logic       event_kind;
	logic [7:0] glyph_code;
	logic       bold_on;
	logic       cfg_we;
	logic       cfg_index;
	logic       cfg_data;

	// events still owed by the block, oldest first
	event_t pending_events[$];

	int fault_count;
	int sent_words;
	int send_gap_pct;
	int recv_stall_pct;

	// predictor copy of the parser state and the two config bits
	mode_t      tok_mode;
	logic       esc_wait;
	logic       close_tag;
	logic       bold_arm;
	logic [4:0] name_len;
	logic [7:0] bold_depth;
	logic       markup_on;
	logic       escape_on;

	markup_text_tokenizer_core #(
		.NAME_LIMIT(TAG_NAME_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_kind(event_kind),
		.glyph_code(glyph_code),
		.bold_on   (bold_on),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("markup_text_tokenizer_core_tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// only A-Z fold down, everything else is left alone
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	function automatic void clear_tokens();
		tok_mode  = MODE_TEXT;
		esc_wait  = 1'b0;
		close_tag = 1'b0;
		bold_arm  = 1'b0;
		name_len  = '0;
	endfunction

	// close of a tag: apply the armed bold step, clamp at both ends
	function automatic void end_tag();
		if (bold_arm) begin
			if (close_tag) begin
				if (bold_depth != 8'd0) begin
					bold_depth = bold_depth - 8'd1;
				end
			end else if (bold_depth != BOLD_MAX) begin
				bold_depth = bold_depth + 8'd1;
			end
		end
		tok_mode  = MODE_TEXT;
		close_tag = 1'b0;
		bold_arm  = 1'b0;
		name_len  = '0;
	endfunction

	// one byte after escape handling; bold flag is taken at the moment of the event
	function automatic void parse_byte(input logic [7:0] c, output bit has_event,
		output event_t ev);
		has_event = 1'b0;
		ev        = '0;
		case (tok_mode)
		MODE_OPEN: begin
			if (c == CH_GT) begin
				// empty tag is dropped
				tok_mode = MODE_TEXT;
			end else if (c == CH_LT) begin
				// doubled open bracket draws a literal one
				tok_mode  = MODE_TEXT;
				has_event = 1'b1;
				ev        = '{KIND_GLYPH, CH_LT, bold_depth != 8'd0};
			end else begin
				tok_mode  = MODE_NAME;
				close_tag = (c == CH_SLASH);
				bold_arm  = (fold_case(c) == CH_B);
				name_len  = '0;
			end
		end
		MODE_NAME: begin
			if (c == CH_LT || c == CH_GT) begin
				end_tag();
			end else begin
				// a closing tag decides on the byte right after the slash
				if (close_tag && name_len == '0) begin
					bold_arm = (fold_case(c) == CH_B);
				end
				name_len = name_len + 5'd1;
				if (name_len >= TAG_NAME_MAX) begin
					end_tag();
				end
			end
		end
		default: begin
			tok_mode = MODE_TEXT;
			if (c == CH_LT && markup_on) begin
				tok_mode = MODE_OPEN;
			end else if (c == CH_NUL || c == CH_LF) begin
				has_event = 1'b1;
				ev        = '{KIND_BREAK, 8'h00, bold_depth != 8'd0};
			end else begin
				has_event = 1'b1;
				ev        = '{KIND_GLYPH, c, bold_depth != 8'd0};
			end
		end
		endcase
	endfunction

	// full per-word update: escape stage, parser, then end-of-text reset
	function automatic void predict_word(input logic [7:0] c, input logic last);
		bit     has_event;
		event_t ev;
		has_event = 1'b0;
		if (esc_wait) begin
			esc_wait = 1'b0;
			parse_byte((c == CH_N) ? CH_LF : c, has_event, ev);
		end else if (c == CH_BSL && escape_on) begin
			esc_wait = 1'b1;
		end else begin
			parse_byte(c, has_event, ev);
		end
		if (has_event) begin
			pending_events.push_back(ev);
		end
		if (last) begin
			clear_tokens();
			bold_depth = 8'd0;
		end
	endfunction

	// ------------------------------------------------------------------
	// event checker: every accepted output word against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_events
		event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS) begin
					$display("%0t: unexpected event kind=%0b glyph=%02h bold=%0b",
						$realtime, event_kind, glyph_code, bold_on);
				end
			end else begin
				want = pending_events.pop_front();
				if (want.kind !== event_kind || want.glyph !== glyph_code ||
					want.bold !== bold_on) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS) begin
						$display({"%0t: event mismatch exp kind=%0b glyph=%02h bold=%0b",
							" got kind=%0b glyph=%02h bold=%0b"},
							$realtime, want.kind, want.glyph, want.bold,
							event_kind, glyph_code, bold_on);
					end
				end
			end
		end
	end

	// receiver side back-pressure, re-rolled every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// stimulus helpers, all entered and left just after a falling edge
	// ------------------------------------------------------------------

	// one input word: optional sender gap, hold until accepted, then predict
	task automatic send_word(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= last;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_word(c, last);
		sent_words++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], 1'b0);
		end
	endtask

	// sender pauses until the block has delivered everything owed
	task automatic drain_events();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_events.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// drained, then idle for SETTLE_CYCLES so a byte that made no event has cleared the pipe too
	task automatic settle_idle();
		drain_events();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// writes both registers back to back, block must be idle
	task automatic set_config(input logic markup, input logic escape);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MARKUP;
		cfg_data  <= markup;
		@(negedge clk);
		cfg_index <= CFG_ESCAPE;
		cfg_data  <= escape;
		@(negedge clk);
		cfg_we    <= 1'b0;
		markup_on = markup;
		escape_on = escape;
	endtask

	function automatic logic [7:0] name_filler();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_LT || c == CH_GT) begin
			c = CH_B + 8'd1;
		end
		return c;
	endfunction

	function automatic logic maybe_last();
		return ($urandom_range(0, 59) == 0);
	endfunction

	function automatic logic [7:0] pick_b();
		return $urandom_range(0, 1) ? CH_B : CH_B - CASE_OFS;
	endfunction

	function automatic logic [7:0] tag_close();
		return ($urandom_range(0, 3) == 0) ? CH_LT : CH_GT;
	endfunction

	// one random fragment of text: single bytes, tags, escapes, line breaks or raw noise
	task automatic send_fragment();
		case ($urandom_range(0, 11))
		0, 1, 2: begin
			send_word(8'($urandom_range(32, 126)), maybe_last());
		end
		3: begin
			// bold open tag
			send_word(CH_LT, maybe_last());
			send_word(pick_b(), maybe_last());
			repeat ($urandom_range(0, 3)) send_word(name_filler(), maybe_last());
			send_word(tag_close(), maybe_last());
		end
		4: begin
			// closing tag, usually a bold one
			send_word(CH_LT, maybe_last());
			send_word(CH_SLASH, maybe_last());
			send_word(($urandom_range(0, 3) == 0) ? name_filler() : pick_b(), maybe_last());
			repeat ($urandom_range(0, 3)) send_word(name_filler(), maybe_last());
			send_word(tag_close(), maybe_last());
		end
		5: begin
			// any other tag
			send_word(CH_LT, maybe_last());
			send_word(8'($urandom_range(0, 255)), maybe_last());
			repeat ($urandom_range(0, 5)) send_word(name_filler(), maybe_last());
			send_word(tag_close(), maybe_last());
		end
		6: begin
			send_word(CH_LT, maybe_last());
			send_word($urandom_range(0, 1) ? CH_LT : CH_GT, maybe_last());
		end
		7: begin
			// name length around the length cut-off, on either side of it
			send_word(CH_LT, 1'b0);
			send_word($urandom_range(0, 1) ? pick_b() : CH_SLASH, 1'b0);
			repeat ($urandom_range(TAG_NAME_MAX - 3, TAG_NAME_MAX + 3))
				send_word(name_filler(), 1'b0);
			send_word(CH_GT, maybe_last());
		end
		8: begin
			send_word(CH_BSL, maybe_last());
			case ($urandom_range(0, 3))
			0: send_word(CH_N, maybe_last());
			1: send_word(CH_BSL, maybe_last());
			2: send_word(CH_LT, maybe_last());
			default: send_word(8'($urandom_range(0, 255)), maybe_last());
			endcase
		end
		9: begin
			send_word($urandom_range(0, 1) ? CH_NUL : CH_LF, maybe_last());
		end
		default: begin
			// raw noise, also flips the end-of-text flag often
			send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
		end
		endcase
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// markup and escapes off: every byte is text, only 0 and 10 break lines
	task automatic test_plain_bytes();
		settle_idle();
		set_config(1'b0, 1'b0);
		send_word(CH_NUL, 1'b0);
		send_word(CH_LF, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(CH_LT, 1'b0);
		send_word(CH_UC_A, 1'b0);
		send_word(CH_BSL, 1'b0);
		send_word(8'h7f, 1'b1);
	endtask

	// tag forms, bold up/down, tag cut by an open bracket, dropped on end of text
	task automatic test_tags();
		settle_idle();
		set_config(1'b1, 1'b0);
		send_text("<<<>x<B>y</b>z</b>v<b<w");
		// line break bytes inside a tag are just name bytes
		send_word(CH_LT, 1'b0);
		send_word(CH_B, 1'b0);
		send_word(CH_LF, 1'b0);
		send_word(CH_GT, 1'b0);
		send_text("</B");
		send_word("q", 1'b1);
		send_word("r", 1'b0);
	endtask

	// backslash escapes, including an escaped tag mark and an escape cut by end of text
	task automatic test_escapes();
		settle_idle();
		set_config(1'b1, 1'b1);
		send_text("\\n\\\\\\<b>x\\y</b>");
		send_word(CH_BSL, 1'b1);
		send_word(CH_N, 1'b0);
	endtask

	// config flips while a tag or an escape is still open
	task automatic test_open_token_config();
		settle_idle();
		set_config(1'b1, 1'b1);
		send_word(CH_LT, 1'b0);
		settle_idle();
		set_config(1'b0, 1'b1);
		// tag still finishes and applies bold
		send_text("b>k");
		send_word(CH_BSL, 1'b0);
		settle_idle();
		set_config(1'b0, 1'b0);
		// escape still finishes, backslash n gives a break
		send_word(CH_N, 1'b0);
		send_word(CH_LT, 1'b0);
		send_word("e", 1'b1);
	endtask

	// bold level saturates at the top and floors at zero
	task automatic test_bold_limits();
		settle_idle();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		set_config(1'b1, 1'b0);
		// the last of these opens is clipped at the top
		repeat (256) send_text("<b>");
		send_word("p", 1'b0);
		send_text("</b>p");
		send_word("p", 1'b1);
		// from zero: one step up, back down, then one more held at the floor
		send_text("<b>p</b>p</b>p");
		send_word("p", 1'b1);
	endtask

	// random traffic across the idling mixes, a mid-phase drain in each
	task automatic test_random_traffic();
		int phase_words;
		int start_words;
		phase_words = RANDOM_WORDS / 4;
		for (int phase = 0; phase < 4; phase++) begin
			settle_idle();
			case (phase)
			0: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
				set_config(1'b1, 1'b1);
			end
			1: begin
				send_gap_pct   = 66;
				recv_stall_pct = 0;
				set_config(1'b1, 1'b0);
			end
			2: begin
				send_gap_pct   = 0;
				recv_stall_pct = 66;
				set_config(1'b0, 1'b1);
			end
			default: begin
				send_gap_pct   = 17;
				recv_stall_pct = 17;
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			endcase
			start_words = sent_words;
			while (sent_words - start_words < phase_words / 2) begin
				send_fragment();
			end
			// hold the sender off until the output side has caught up
			drain_events();
			while (sent_words - start_words < phase_words) begin
				send_fragment();
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		char_code      = '0;
		last_char      = 1'b0;
		out_stall      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_MARKUP;
		cfg_data       = 1'b0;
		fault_count    = 0;
		sent_words     = 0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		markup_on      = 1'b0;
		escape_on      = 1'b0;
		bold_depth     = 8'd0;
		clear_tokens();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part with light idling on both sides, none in the bold limit test
		send_gap_pct   = 17;
		recv_stall_pct = 17;
		test_plain_bytes();
		test_tags();
		test_escapes();
		test_open_token_config();
		test_bold_limits();
		test_random_traffic();

		settle_idle();
		if (fault_count == 0) begin
			$display("markup_text_tokenizer_core_tb OK");
		end else begin
			$display("markup_text_tokenizer_core_tb NOT OK");
		end
		$finish;
	end

endmodule
